[sv/smt_pkg.sv]
// ----------------------------------------------------------------------------
// smt_pkg: shared types and constants for the stereo midpoint triangulation unit
// Widths of the fixed-point datapath, register indexes and result records.
// ----------------------------------------------------------------------------
package smt_pkg;

  localparam int unsigned CoordW = 16;              // image coordinate
  localparam int unsigned CfgW   = 32;              // widest register
  localparam int unsigned PlW    = CoordW + 1;      // centered ray component
  localparam int unsigned TW     = 24;              // baseline component
  localparam int unsigned PixW   = 32;              // pixel size
  localparam int unsigned PW     = 2 * PlW;         // ray product
  localparam int unsigned TPW    = TW + PlW;        // baseline by ray product
  localparam int unsigned WW     = PW + 1;          // cross product component
  localparam int unsigned TpW    = TPW + 1;         // baseline cross ray
  localparam int unsigned SqW    = 2 * WW;
  localparam int unsigned TwW    = TpW + WW;
  localparam int unsigned WtW    = WW + TW;
  localparam int unsigned DW     = SqW + 1;         // determinant magnitude
  localparam int unsigned NaW    = TwW + 3;
  localparam int unsigned NcW    = WtW + 3;
  localparam int unsigned TpSplit = TpW / 2;
  localparam int unsigned TwhW   = TpW - TpSplit + WW;
  localparam int unsigned TwlW   = TpSplit + 1 + WW;
  localparam int unsigned NaSplit = NaW / 2;
  localparam int unsigned NcSplit = NcW / 2;
  localparam int unsigned AhW    = NaW - NaSplit + PlW;
  localparam int unsigned AlW    = NaSplit + 1 + PlW;
  localparam int unsigned ChW    = NcW - NcSplit + WW;
  localparam int unsigned ClW    = NcSplit + 1 + WW;
  localparam int unsigned NumW   = 96;              // numerator before scaling
  localparam int unsigned Chunks = NumW / PixW;
  localparam int unsigned PpW    = 2 * PixW;
  localparam int unsigned ProdW  = NumW + PixW;     // scaled numerator magnitude
  localparam int unsigned DenShift = 13;
  localparam int unsigned DenW   = DW + DenShift;
  localparam int unsigned QW     = 48;              // quotient and result width
  localparam int unsigned RemW   = DenW + 1;
  localparam int unsigned HiW    = ProdW - QW;

  localparam int BaselineYDefault = 0;
  localparam int BaselineZDefault = 0;

  localparam logic [CoordW-1:0] FocalReset = 16'h4000;
  localparam logic [PixW-1:0]   PixelReset = 32'h0100_0000;

  localparam logic [QW:0] PosLimit = {2'b00, {(QW-1){1'b1}}};
  localparam logic [QW:0] NegLimit = {2'b01, {(QW-1){1'b0}}};

  typedef enum logic [2:0] {
    CfgLeftCx,
    CfgLeftCy,
    CfgRightCx,
    CfgRightCy,
    CfgLeftFocal,
    CfgRightFocal,
    CfgBaselineX,
    CfgPixelSize
  } cfg_idx_e;

  typedef struct packed {
    logic       sing;
    logic [2:0] neg;
    logic [2:0] sat;
  } smt_side_t;

  typedef struct packed {
    logic signed [QW-1:0] x;
    logic signed [QW-1:0] y;
    logic signed [QW-1:0] z;
    logic                 sing;
    logic                 sat;
  } smt_result_t;

endpackage

[sv/smt_divider.sv]
// ----------------------------------------------------------------------------
// smt_divider: pipelined restoring divider, one quotient bit per stage
// Starts from a partial remainder below the divisor and produces the low
// quotient bits together with the final remainder for rounding.
// ----------------------------------------------------------------------------
module smt_divider (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic [smt_pkg::RemW-1:0]   rem_i,
  input  logic [smt_pkg::QW-1:0]     low_i,
  input  logic [smt_pkg::DenW-1:0]   den_i,
  output logic [smt_pkg::QW-1:0]     quot_o,
  output logic [smt_pkg::RemW-1:0]   rem_o,
  output logic [smt_pkg::DenW-1:0]   den_o
);

  localparam int unsigned Steps = smt_pkg::QW;

  logic [smt_pkg::RemW-1:0] rem_src [Steps];
  logic [smt_pkg::QW-1:0]   low_src [Steps];
  logic [smt_pkg::DenW-1:0] den_src [Steps];
  logic [smt_pkg::RemW-1:0] rem_d   [Steps];
  logic [smt_pkg::QW-1:0]   low_d   [Steps];
  logic [smt_pkg::RemW-1:0] rem_q   [Steps];
  logic [smt_pkg::QW-1:0]   low_q   [Steps];
  logic [smt_pkg::DenW-1:0] den_q   [Steps];

  always_comb begin
    rem_src[0] = rem_i;
    low_src[0] = low_i;
    den_src[0] = den_i;
    for (int s = 1; s < Steps; s++) begin
      rem_src[s] = rem_q[s-1];
      low_src[s] = low_q[s-1];
      den_src[s] = den_q[s-1];
    end
  end

  // dividend bits leave at the top of low, quotient bits enter at the bottom
  always_comb begin
    logic [smt_pkg::RemW-1:0] trial;
    logic                     ge;
    trial = '0;
    ge    = 1'b0;
    for (int s = 0; s < Steps; s++) begin
      trial    = {rem_src[s][smt_pkg::RemW-2:0], low_src[s][smt_pkg::QW-1]};
      ge       = trial >= smt_pkg::RemW'(den_src[s]);
      rem_d[s] = ge ? trial - smt_pkg::RemW'(den_src[s]) : trial;
      low_d[s] = {low_src[s][smt_pkg::QW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int s = 0; s < Steps; s++) begin
        rem_q[s] <= rem_d[s];
        low_q[s] <= low_d[s];
        den_q[s] <= den_src[s];
      end
    end
  end

  assign quot_o = low_q[Steps-1];
  assign rem_o  = rem_q[Steps-1];
  assign den_o  = den_q[Steps-1];

endmodule

[sv/stereo_midpoint_triangulation_unit.sv]
// ----------------------------------------------------------------------------
// stereo_midpoint_triangulation_unit: midpoint triangulation of a stereo pair
// Turns one matched left/right feature pair into a saturated 3-D point.
// ----------------------------------------------------------------------------
// Usage: a feature pair transfers on the input channel when in_valid_i is high
// and in_stall_o is low; the point transfers on the output channel when
// out_valid_o is high and out_stall_i is low. One result per pair, in order.
// It takes one pair per cycle while in_stall_o is low. The pipeline has 11
// stages of ray, cross product, determinant and scaling arithmetic (each
// holds at most one 32-bit class multiplier or a wide add), 48 stages of a
// restoring divider with one quotient bit per stage, then a rounding and a
// saturation stage. A one-entry skid buffer sits at the output: when the
// receiver stalls, the pipeline keeps moving until the skid entry fills, and
// only then does in_stall_o rise. Configuration registers are written through
// cfg_we_i, cfg_index_i and cfg_data_i, by the user only while no pair is in
// flight; the block does not enforce this. Reset empties the pipeline and
// loads centers 0, focals 16384, baseline 0, pixel size 2^24. A zero
// determinant gives a zero point with singular_o set.
// ----------------------------------------------------------------------------
module stereo_midpoint_triangulation_unit #(
  parameter int BASELINE_Y = smt_pkg::BaselineYDefault,
  parameter int BASELINE_Z = smt_pkg::BaselineZDefault
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [2:0]                      cfg_index_i,
  input  logic [smt_pkg::CfgW-1:0]        cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [smt_pkg::CoordW-1:0]      left_x_i,
  input  logic [smt_pkg::CoordW-1:0]      left_y_i,
  input  logic [smt_pkg::CoordW-1:0]      right_x_i,
  input  logic [smt_pkg::CoordW-1:0]      right_y_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic signed [smt_pkg::QW-1:0]   point_x_o,
  output logic signed [smt_pkg::QW-1:0]   point_y_o,
  output logic signed [smt_pkg::QW-1:0]   point_z_o,
  output logic                            singular_o,
  output logic                            saturated_o
);

  localparam logic signed [smt_pkg::TW-1:0] BaseY = smt_pkg::TW'(BASELINE_Y);
  localparam logic signed [smt_pkg::TW-1:0] BaseZ = smt_pkg::TW'(BASELINE_Z);
  localparam int unsigned NStage = 11;

  // configuration
  logic [smt_pkg::CoordW-1:0] lcx_q, lcy_q, rcx_q, rcy_q, lf_q, rf_q;
  logic signed [smt_pkg::TW-1:0] bx_q;
  logic [smt_pkg::PixW-1:0] pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lcx_q <= '0;
      lcy_q <= '0;
      rcx_q <= '0;
      rcy_q <= '0;
      lf_q  <= smt_pkg::FocalReset;
      rf_q  <= smt_pkg::FocalReset;
      bx_q  <= '0;
      pix_q <= smt_pkg::PixelReset;
    end else if (cfg_we_i) begin
      case (smt_pkg::cfg_idx_e'(cfg_index_i))
        smt_pkg::CfgLeftCx:     lcx_q <= cfg_data_i[smt_pkg::CoordW-1:0];
        smt_pkg::CfgLeftCy:     lcy_q <= cfg_data_i[smt_pkg::CoordW-1:0];
        smt_pkg::CfgRightCx:    rcx_q <= cfg_data_i[smt_pkg::CoordW-1:0];
        smt_pkg::CfgRightCy:    rcy_q <= cfg_data_i[smt_pkg::CoordW-1:0];
        smt_pkg::CfgLeftFocal:  lf_q  <= cfg_data_i[smt_pkg::CoordW-1:0];
        smt_pkg::CfgRightFocal: rf_q  <= cfg_data_i[smt_pkg::CoordW-1:0];
        smt_pkg::CfgBaselineX:  bx_q  <= $signed(cfg_data_i[smt_pkg::TW-1:0]);
        smt_pkg::CfgPixelSize:  pix_q <= cfg_data_i[smt_pkg::PixW-1:0];
        default: ;
      endcase
    end
  end

  logic signed [smt_pkg::TW-1:0] t_s [3];
  assign t_s[0] = bx_q;
  assign t_s[1] = BaseY;
  assign t_s[2] = BaseZ;

  // handshake and pipeline advance
  logic adv;
  logic skid_v_q;
  logic [NStage-1:0] v_q;
  logic [smt_pkg::QW-1:0] dv_q;
  logic v60_q, vp_q;

  assign adv        = !skid_v_q;
  assign in_stall_o = skid_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q   <= '0;
      dv_q  <= '0;
      v60_q <= 1'b0;
      vp_q  <= 1'b0;
    end else if (adv) begin
      v_q   <= {v_q[NStage-2:0], in_valid_i};
      dv_q  <= {dv_q[smt_pkg::QW-2:0], v_q[NStage-1]};
      v60_q <= dv_q[smt_pkg::QW-1];
      vp_q  <= v60_q;
    end
  end

  // stage 1: centered rays
  logic signed [smt_pkg::PlW-1:0] s1_pl_q [3], s1_pr_q [3];
  // stage 2: cross product terms
  logic signed [smt_pkg::PW-1:0]  s2_wa_q [3], s2_wb_q [3];
  logic signed [smt_pkg::TPW-1:0] s2_ta_q [3], s2_tb_q [3];
  logic signed [smt_pkg::PlW-1:0] s2_pl_q [3];
  // stage 3: w and T x pr
  logic signed [smt_pkg::WW-1:0]  s3_w_q [3];
  logic signed [smt_pkg::TpW-1:0] s3_tp_q [3];
  logic signed [smt_pkg::PlW-1:0] s3_pl_q [3];
  // stage 4: dot product terms
  logic signed [smt_pkg::SqW-1:0]  s4_sq_q [3];
  logic signed [smt_pkg::TwhW-1:0] s4_twh_q [3];
  logic signed [smt_pkg::TwlW-1:0] s4_twl_q [3];
  logic signed [smt_pkg::WtW-1:0]  s4_wt_q [3];
  logic signed [smt_pkg::WW-1:0]   s4_w_q [3];
  logic signed [smt_pkg::PlW-1:0]  s4_pl_q [3];
  // stage 5: determinant and numerators
  logic [smt_pkg::DW-1:0]         s5_d_q;
  logic signed [smt_pkg::NaW-1:0] s5_na_q;
  logic signed [smt_pkg::NcW-1:0] s5_nc_q;
  logic signed [smt_pkg::WW-1:0]  s5_w_q [3];
  logic signed [smt_pkg::PlW-1:0] s5_pl_q [3];
  // stage 6: split products
  logic signed [smt_pkg::AhW-1:0] s6_ah_q [3];
  logic signed [smt_pkg::AlW-1:0] s6_al_q [3];
  logic signed [smt_pkg::ChW-1:0] s6_ch_q [3];
  logic signed [smt_pkg::ClW-1:0] s6_cl_q [3];
  logic [smt_pkg::DW-1:0]         s6_d_q;
  // stage 7: numerators, divisor
  logic signed [smt_pkg::NumW-1:0] s7_num_q [3];
  logic [smt_pkg::DenW-1:0]        s7_den_q;
  logic                            s7_sing_q;
  // stage 8: magnitude and sign
  logic [smt_pkg::NumW-1:0] s8_mag_q [3];
  logic [2:0]               s8_neg_q;
  logic [smt_pkg::DenW-1:0] s8_den_q;
  logic                     s8_sing_q;
  // stage 9: pixel size partial products
  logic [smt_pkg::PpW-1:0]  s9_pp_q [3][smt_pkg::Chunks];
  logic [2:0]               s9_neg_q;
  logic [smt_pkg::DenW-1:0] s9_den_q;
  logic                     s9_sing_q;
  // stage 10: scaled magnitude
  logic [smt_pkg::ProdW-1:0] s10_m_q [3];
  logic [2:0]                s10_neg_q;
  logic [smt_pkg::DenW-1:0]  s10_den_q;
  logic                      s10_sing_q;
  // stage 11: divider entry
  logic [smt_pkg::RemW-1:0]  s11_rem_q [3];
  logic [smt_pkg::QW-1:0]    s11_low_q [3];
  logic [smt_pkg::DenW-1:0]  s11_den_q;
  smt_pkg::smt_side_t        s11_side_q;

  logic signed [smt_pkg::TpW-smt_pkg::TpSplit-1:0] tp_h [3];
  logic signed [smt_pkg::TpSplit:0]                tp_l [3];
  logic signed [smt_pkg::NaW-1:0]                  tw_s [3];
  logic signed [smt_pkg::NaW-smt_pkg::NaSplit-1:0] na_h;
  logic signed [smt_pkg::NaSplit:0]                na_l;
  logic signed [smt_pkg::NcW-smt_pkg::NcSplit-1:0] nc_h;
  logic signed [smt_pkg::NcSplit:0]                nc_l;
  logic signed [smt_pkg::DW:0]                     d_sum;
  logic signed [smt_pkg::NumW-1:0]                 num_d [3];
  logic [smt_pkg::HiW-1:0]                         hi_s [3];
  logic [2:0]                                      satpre_d;

  assign na_h  = $signed(s5_na_q[smt_pkg::NaW-1:smt_pkg::NaSplit]);
  assign na_l  = $signed({1'b0, s5_na_q[smt_pkg::NaSplit-1:0]});
  assign nc_h  = $signed(s5_nc_q[smt_pkg::NcW-1:smt_pkg::NcSplit]);
  assign nc_l  = $signed({1'b0, s5_nc_q[smt_pkg::NcSplit-1:0]});
  assign d_sum = s4_sq_q[0] + s4_sq_q[1] + s4_sq_q[2];

  always_comb begin
    logic signed [smt_pkg::NumW-1:0] ah, al, ch, cl;
    ah = '0;
    al = '0;
    ch = '0;
    cl = '0;
    for (int k = 0; k < 3; k++) begin
      tp_h[k] = $signed(s3_tp_q[k][smt_pkg::TpW-1:smt_pkg::TpSplit]);
      tp_l[k] = $signed({1'b0, s3_tp_q[k][smt_pkg::TpSplit-1:0]});
      tw_s[k] = (smt_pkg::NaW'(s4_twh_q[k]) <<< smt_pkg::TpSplit)
              + smt_pkg::NaW'(s4_twl_q[k]);
      ah = s6_ah_q[k];
      al = s6_al_q[k];
      ch = s6_ch_q[k];
      cl = s6_cl_q[k];
      num_d[k] = (((ah <<< smt_pkg::NaSplit) + al) <<< 1) + (ch <<< smt_pkg::NcSplit) + cl;
      hi_s[k]  = s10_m_q[k][smt_pkg::ProdW-1:smt_pkg::QW];
      // quotient would need more than the result width
      satpre_d[k] = smt_pkg::RemW'(hi_s[k]) >= smt_pkg::RemW'(s10_den_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pl_q[0] <= $signed({1'b0, left_x_i}) - $signed({1'b0, lcx_q});
      s1_pl_q[1] <= $signed({1'b0, left_y_i}) - $signed({1'b0, lcy_q});
      s1_pl_q[2] <= $signed({1'b0, lf_q});
      s1_pr_q[0] <= $signed({1'b0, right_x_i}) - $signed({1'b0, rcx_q});
      s1_pr_q[1] <= $signed({1'b0, right_y_i}) - $signed({1'b0, rcy_q});
      s1_pr_q[2] <= $signed({1'b0, rf_q});

      s2_wa_q[0] <= s1_pl_q[1] * s1_pr_q[2];
      s2_wb_q[0] <= s1_pl_q[2] * s1_pr_q[1];
      s2_wa_q[1] <= s1_pl_q[2] * s1_pr_q[0];
      s2_wb_q[1] <= s1_pl_q[0] * s1_pr_q[2];
      s2_wa_q[2] <= s1_pl_q[0] * s1_pr_q[1];
      s2_wb_q[2] <= s1_pl_q[1] * s1_pr_q[0];
      s2_ta_q[0] <= t_s[1] * s1_pr_q[2];
      s2_tb_q[0] <= t_s[2] * s1_pr_q[1];
      s2_ta_q[1] <= t_s[2] * s1_pr_q[0];
      s2_tb_q[1] <= t_s[0] * s1_pr_q[2];
      s2_ta_q[2] <= t_s[0] * s1_pr_q[1];
      s2_tb_q[2] <= t_s[1] * s1_pr_q[0];

      for (int k = 0; k < 3; k++) begin
        s2_pl_q[k] <= s1_pl_q[k];
        s3_w_q[k]  <= smt_pkg::WW'(s2_wa_q[k]) - smt_pkg::WW'(s2_wb_q[k]);
        s3_tp_q[k] <= smt_pkg::TpW'(s2_ta_q[k]) - smt_pkg::TpW'(s2_tb_q[k]);
        s3_pl_q[k] <= s2_pl_q[k];
        s4_sq_q[k]  <= s3_w_q[k] * s3_w_q[k];
        s4_twh_q[k] <= tp_h[k] * s3_w_q[k];
        s4_twl_q[k] <= tp_l[k] * s3_w_q[k];
        s4_wt_q[k]  <= s3_w_q[k] * t_s[k];
        s4_w_q[k]  <= s3_w_q[k];
        s4_pl_q[k] <= s3_pl_q[k];
        s5_w_q[k]  <= s4_w_q[k];
        s5_pl_q[k] <= s4_pl_q[k];
        s6_ah_q[k] <= na_h * s5_pl_q[k];
        s6_al_q[k] <= na_l * s5_pl_q[k];
        s6_ch_q[k] <= nc_h * s5_w_q[k];
        s6_cl_q[k] <= nc_l * s5_w_q[k];
        s7_num_q[k] <= num_d[k];
        s8_mag_q[k] <= s7_num_q[k][smt_pkg::NumW-1] ? $unsigned(-s7_num_q[k])
                                                     : $unsigned(s7_num_q[k]);
        s8_neg_q[k] <= s7_num_q[k][smt_pkg::NumW-1];
        for (int j = 0; j < smt_pkg::Chunks; j++) begin
          s9_pp_q[k][j] <= s8_mag_q[k][smt_pkg::PixW*j +: smt_pkg::PixW] * pix_q;
        end
        s10_m_q[k] <= smt_pkg::ProdW'(s9_pp_q[k][0])
                    + (smt_pkg::ProdW'(s9_pp_q[k][1]) << smt_pkg::PixW)
                    + (smt_pkg::ProdW'(s9_pp_q[k][2]) << (2 * smt_pkg::PixW));
        s11_rem_q[k] <= satpre_d[k] ? '0 : smt_pkg::RemW'(hi_s[k]);
        s11_low_q[k] <= s10_m_q[k][smt_pkg::QW-1:0];
      end

      s5_d_q  <= d_sum[smt_pkg::DW-1:0];
      s5_na_q <= -(tw_s[0] + tw_s[1] + tw_s[2]);
      s5_nc_q <= -(s4_wt_q[0] + s4_wt_q[1] + s4_wt_q[2]);
      s6_d_q  <= s5_d_q;
      s7_den_q  <= {s6_d_q, {smt_pkg::DenShift{1'b0}}};
      s7_sing_q <= s6_d_q == '0;
      s8_den_q  <= s7_den_q;
      s8_sing_q <= s7_sing_q;
      s9_neg_q  <= s8_neg_q;
      s9_den_q  <= s8_den_q;
      s9_sing_q <= s8_sing_q;
      s10_neg_q  <= s9_neg_q;
      s10_den_q  <= s9_den_q;
      s10_sing_q <= s9_sing_q;
      s11_den_q       <= s10_den_q;
      s11_side_q.sing <= s10_sing_q;
      s11_side_q.neg  <= s10_neg_q;
      s11_side_q.sat  <= satpre_d;
    end
  end

  // divider lanes
  logic [smt_pkg::QW-1:0]   quot_s [3];
  logic [smt_pkg::RemW-1:0] drem_s [3];
  logic [smt_pkg::DenW-1:0] dden_s [3];

  for (genvar k = 0; k < 3; k++) begin : g_div
    smt_divider u_div (
      .clk_i  (clk_i),
      .en_i   (adv),
      .rem_i  (s11_rem_q[k]),
      .low_i  (s11_low_q[k]),
      .den_i  (s11_den_q),
      .quot_o (quot_s[k]),
      .rem_o  (drem_s[k]),
      .den_o  (dden_s[k])
    );
  end

  smt_pkg::smt_side_t side_q [smt_pkg::QW];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      side_q[0] <= s11_side_q;
      for (int s = 1; s < smt_pkg::QW; s++) begin
        side_q[s] <= side_q[s-1];
      end
    end
  end

  // rounding: half or more of the divisor left over rounds away from zero
  logic [smt_pkg::QW:0] s60_q_q [3];
  smt_pkg::smt_side_t   s60_side_q;
  logic [2:0]           rnd_s;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      rnd_s[k] = {drem_s[k], 1'b0} >= (smt_pkg::RemW + 1)'(dden_s[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        s60_q_q[k] <= {1'b0, quot_s[k]} + (smt_pkg::QW + 1)'(rnd_s[k]);
      end
      s60_side_q <= side_q[smt_pkg::QW-1];
    end
  end

  // saturation and sign
  logic signed [smt_pkg::QW-1:0] val_s [3];
  logic [2:0]                    sat_s;
  smt_pkg::smt_result_t          res_d, res_q, skid_q;

  always_comb begin
    logic [smt_pkg::QW:0] lim;
    lim = '0;
    for (int k = 0; k < 3; k++) begin
      lim      = s60_side_q.neg[k] ? smt_pkg::NegLimit : smt_pkg::PosLimit;
      sat_s[k] = s60_side_q.sat[k] || (s60_q_q[k] > lim);
      if (s60_side_q.sing) begin
        val_s[k] = '0;
      end else if (sat_s[k]) begin
        val_s[k] = s60_side_q.neg[k] ? $signed(smt_pkg::NegLimit[smt_pkg::QW-1:0])
                                     : $signed(smt_pkg::PosLimit[smt_pkg::QW-1:0]);
      end else if (s60_side_q.neg[k]) begin
        val_s[k] = -$signed(s60_q_q[k][smt_pkg::QW-1:0]);
      end else begin
        val_s[k] = $signed(s60_q_q[k][smt_pkg::QW-1:0]);
      end
    end
    res_d.x    = val_s[0];
    res_d.y    = val_s[1];
    res_d.z    = val_s[2];
    res_d.sing = s60_side_q.sing;
    res_d.sat  = !s60_side_q.sing && (sat_s != '0);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  // output skid entry catches the last stage when the receiver stalls
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
    end else if (!skid_v_q) begin
      skid_v_q <= vp_q && out_stall_i;
    end else if (!out_stall_i) begin
      skid_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!skid_v_q && vp_q && out_stall_i) begin
      skid_q <= res_q;
    end
  end

  smt_pkg::smt_result_t out_s;
  assign out_s       = skid_v_q ? skid_q : res_q;
  assign out_valid_o = skid_v_q || vp_q;
  assign point_x_o   = out_s.x;
  assign point_y_o   = out_s.y;
  assign point_z_o   = out_s.z;
  assign singular_o  = out_s.sing;
  assign saturated_o = out_s.sat;

  a_sing_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && singular_o |-> point_x_o == '0 && point_y_o == '0 &&
                                  point_z_o == '0 && !saturated_o)
    else $error("singular result with nonzero point");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o)
    else $error("input stalled without a waiting result");

  a_skid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q && out_stall_i |=> skid_v_q && $stable(skid_q))
    else $error("skid entry lost while stalled");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !skid_v_q && vp_q && out_stall_i |=> skid_v_q)
    else $error("stalled result not captured");

endmodule

[dv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the stereo midpoint triangulation unit
// Streams feature pairs through several register settings, predicts each
// point with exact wide integer math and checks every result in order.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BaseY = 0;
  localparam int BaseZ = 0;
  localparam int Drain = 70;
  localparam int WatchLimit = 4000;

  typedef struct {
    logic [15:0] lx, ly, rx, ry;
  } pair_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [2:0] cfg_index_i = '0;
  logic [smt_pkg::CfgW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic [smt_pkg::CoordW-1:0] left_x_i = '0, left_y_i = '0, right_x_i = '0, right_y_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic signed [smt_pkg::QW-1:0] point_x_o, point_y_o, point_z_o;
  logic singular_o, saturated_o;

  stereo_midpoint_triangulation_unit #(.BASELINE_Y(BaseY), .BASELINE_Z(BaseZ)) dut (.*);

  always #1 clk_i = ~clk_i;

  // register shadow
  logic [15:0] lcx = '0, lcy = '0, rcx = '0, rcy = '0;
  logic [15:0] lfoc = smt_pkg::FocalReset, rfoc = smt_pkg::FocalReset;
  logic [23:0] base_x = '0;
  logic [31:0] pix = smt_pkg::PixelReset;

  pair_t pending_pairs[$];
  smt_pkg::smt_result_t expected_points[$];
  int errors = 0;
  bit quiet = 1'b0;
  bit hold_go = 1'b0;
  bit in_taken = 1'b0;
  int in_idle = 0, out_idle = 0, hold_left = 0, watch = 0;

  function automatic smt_pkg::smt_result_t triangulate(pair_t p);
    logic signed [255:0] pl[3], pr[3], w[3], t[3], tp[3];
    logic signed [255:0] d, na, nc, num, den, mag, q, scale;
    logic signed [255:0] lim_pos, lim_neg;
    logic signed [47:0] c[3];
    smt_pkg::smt_result_t r;
    bit neg;
    r = '0;
    pl[0] = 256'(p.lx) - 256'(lcx);
    pl[1] = 256'(p.ly) - 256'(lcy);
    pl[2] = 256'(lfoc);
    pr[0] = 256'(p.rx) - 256'(rcx);
    pr[1] = 256'(p.ry) - 256'(rcy);
    pr[2] = 256'(rfoc);
    t[0] = $signed(base_x);
    t[1] = $signed(24'(BaseY));
    t[2] = $signed(24'(BaseZ));
    w[0] = pl[1] * pr[2] - pl[2] * pr[1];
    w[1] = pl[2] * pr[0] - pl[0] * pr[2];
    w[2] = pl[0] * pr[1] - pl[1] * pr[0];
    tp[0] = t[1] * pr[2] - t[2] * pr[1];
    tp[1] = t[2] * pr[0] - t[0] * pr[2];
    tp[2] = t[0] * pr[1] - t[1] * pr[0];
    d = w[0] * w[0] + w[1] * w[1] + w[2] * w[2];
    na = -(tp[0] * w[0] + tp[1] * w[1] + tp[2] * w[2]);
    nc = -(w[0] * t[0] + w[1] * t[1] + w[2] * t[2]);
    if (d == 0) begin
      r.sing = 1'b1;
      return r;
    end
    den = d <<< smt_pkg::DenShift;
    scale = 256'(pix);
    lim_pos = (256'(1) <<< 47) - 1;
    lim_neg = 256'(1) <<< 47;
    for (int k = 0; k < 3; k++) begin
      num = (2 * na * pl[k] + nc * w[k]) * scale;
      neg = num < 0;
      mag = neg ? -num : num;
      // round half away from zero
      q = (2 * mag + den) / (2 * den);
      if (q > (neg ? lim_neg : lim_pos)) begin
        r.sat = 1'b1;
        q = neg ? lim_neg : lim_pos;
      end
      c[k] = neg ? -q[47:0] : q[47:0];
    end
    r.x = c[0];
    r.y = c[1];
    r.z = c[2];
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    errors++;
    $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
  endtask

  // monitor: input transfers make predictions, output transfers get checked
  always @(posedge clk_i) begin
    smt_pkg::smt_result_t e;
    in_taken <= in_valid_i && !in_stall_o;
    if (in_valid_i && !in_stall_o)
      expected_points.insert(expected_points.size(),
                             triangulate('{left_x_i, left_y_i, right_x_i, right_y_i}));
    if (out_valid_o && !out_stall_i) begin
      if (expected_points.size() == 0) begin
        report_mismatch("unexpected result", '0, '0);
      end else begin
        e = expected_points.pop_front();
        if (point_x_o !== e.x) report_mismatch("point_x", point_x_o, e.x);
        if (point_y_o !== e.y) report_mismatch("point_y", point_y_o, e.y);
        if (point_z_o !== e.z) report_mismatch("point_z", point_z_o, e.z);
        if (singular_o !== e.sing) report_mismatch("singular", singular_o, e.sing);
        if (saturated_o !== e.sat) report_mismatch("saturated", saturated_o, e.sat);
      end
    end
  end

  // driver
  always @(negedge clk_i) begin
    pair_t p;
    if (!in_valid_i || in_taken) begin
      if (in_idle > 0) begin
        in_valid_i <= 1'b0;
        in_idle <= in_idle - 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        in_valid_i <= 1'b0;
        in_idle <= $urandom_range(0, 9);
      end else if (pending_pairs.size() > 0) begin
        p = pending_pairs.pop_front();
        left_x_i <= p.lx;
        left_y_i <= p.ly;
        right_x_i <= p.rx;
        right_y_i <= p.ry;
        in_valid_i <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // receiver stalls, with one long hold-off on request
  always @(negedge clk_i) begin
    if (hold_go && hold_left == 0) begin
      hold_go <= 1'b0;
      hold_left <= 300;
      out_stall_i <= 1'b1;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (out_idle > 0) begin
      out_idle <= out_idle - 1;
      out_stall_i <= 1'b1;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      out_idle <= $urandom_range(0, 9);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) watch <= 0;
    else watch <= watch + 1;
    if (watch >= WatchLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic write_reg(smt_pkg::cfg_idx_e idx, logic [31:0] data);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    case (idx)
      smt_pkg::CfgLeftCx:     lcx = data[15:0];
      smt_pkg::CfgLeftCy:     lcy = data[15:0];
      smt_pkg::CfgRightCx:    rcx = data[15:0];
      smt_pkg::CfgRightCy:    rcy = data[15:0];
      smt_pkg::CfgLeftFocal:  lfoc = data[15:0];
      smt_pkg::CfgRightFocal: rfoc = data[15:0];
      smt_pkg::CfgBaselineX:  base_x = data[23:0];
      smt_pkg::CfgPixelSize:  pix = data;
      default: ;
    endcase
  endtask

  task automatic load_setting(logic [15:0] cx0, cy0, cx1, cy1, f0, f1,
                              logic [31:0] bx, logic [31:0] ps);
    write_reg(smt_pkg::CfgLeftCx, 32'(cx0));
    write_reg(smt_pkg::CfgLeftCy, 32'(cy0));
    write_reg(smt_pkg::CfgRightCx, 32'(cx1));
    write_reg(smt_pkg::CfgRightCy, 32'(cy1));
    write_reg(smt_pkg::CfgLeftFocal, 32'(f0));
    write_reg(smt_pkg::CfgRightFocal, 32'(f1));
    write_reg(smt_pkg::CfgBaselineX, bx);
    write_reg(smt_pkg::CfgPixelSize, ps);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic drain_all();
    while (pending_pairs.size() > 0 || in_valid_i || expected_points.size() > 0)
      @(posedge clk_i);
    repeat (Drain) @(posedge clk_i);
  endtask

  function automatic pair_t random_pair();
    pair_t p;
    p.lx = 16'($urandom());
    p.ly = 16'($urandom());
    case ($urandom_range(0, 9))
      0: begin  // same image point in both views, singular when the cameras match
        p.rx = p.lx - lcx + rcx;
        p.ry = p.ly - lcy + rcy;
      end
      1: begin  // corner values
        p.lx = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        p.rx = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        p.ry = 16'($urandom());
      end
      2, 3, 4: begin  // small disparity, realistic match
        p.rx = 16'(p.lx + $urandom_range(0, 2047) - 1024);
        p.ry = 16'(p.ly + $urandom_range(0, 63) - 32);
      end
      default: begin
        p.rx = 16'($urandom());
        p.ry = 16'($urandom());
      end
    endcase
    return p;
  endfunction

  task automatic run_random(int n);
    repeat (n) pending_pairs.insert(pending_pairs.size(), random_pair());
  endtask

  initial begin
    pair_t dir[$];
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset setting
    run_random(20);
    drain_all();

    // directed
    load_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h4000, 16'h4000,
                 32'h0000_1000, 32'h0100_0000);
    dir = '{'{16'h0000, 16'h0000, 16'h0000, 16'h0000},
            '{16'hffff, 16'hffff, 16'hffff, 16'hffff},
            '{16'h0123, 16'h0456, 16'h0123, 16'h0456},
            '{16'hffff, 16'h0000, 16'h0000, 16'hffff},
            '{16'h0000, 16'hffff, 16'hffff, 16'h0000},
            '{16'h8000, 16'h8000, 16'h7000, 16'h8000},
            '{16'h1000, 16'h2000, 16'h0f00, 16'h2000},
            '{16'hffff, 16'h8000, 16'h0000, 16'h8000},
            '{16'h0001, 16'h0001, 16'h0000, 16'h0000},
            '{16'haaaa, 16'h5555, 16'h5555, 16'haaaa}};
    foreach (dir[i]) pending_pairs.insert(pending_pairs.size(), dir[i]);
    drain_all();

    // random setting with the long receiver hold-off
    load_setting(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 16'($urandom()), 16'($urandom()), $urandom(), $urandom());
    hold_go = 1'b1;
    run_random(400);
    drain_all();

    // extremes: high centers, zero focals, most negative baseline, widest pixel
    load_setting(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'h0000, 16'h0000,
                 32'hff80_0000, 32'hffff_ffff);
    run_random(380);
    drain_all();

    // extremes the other way
    load_setting(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'hffff, 16'hffff,
                 32'h007f_ffff, 32'h0000_0000);
    run_random(370);
    drain_all();

    // typical cameras, large pixel size to reach saturation
    load_setting(16'h2800, 16'h1e00, 16'h2780, 16'h1e40, 16'h4000, 16'h4100,
                 $urandom(), 32'hf000_0000);
    run_random(380);
    drain_all();

    // last part without idling
    load_setting(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                 16'($urandom()), 16'($urandom()), $urandom(), 32'h0100_0000);
    quiet = 1'b1;
    run_random(380);
    drain_all();

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
